/* design/skf_pkg.sv */
`default_nettype none

package skf_pkg;

   // Fixed-point format of the estimate, the covariance and the gain.
   localparam int FRAC_BITS   = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int NOISE_WIDTH = 24;

   // Gain lies in [0, 1.0], so it needs one integer bit above the fraction.
   localparam int K_WIDTH   = FRAC_BITS + 1;
   localparam int DEN_WIDTH = DATA_WIDTH + 1;
   localparam int REM_WIDTH = DEN_WIDTH + 1;
   localparam int DIFF_WIDTH = DATA_WIDTH + 1;
   localparam int PX_WIDTH  = K_WIDTH + DIFF_WIDTH;
   localparam int PP_WIDTH  = K_WIDTH + DATA_WIDTH;
   localparam int CNT_WIDTH = $clog2(K_WIDTH);

   localparam logic [DATA_WIDTH-1:0]  COV_ONE     = DATA_WIDTH'(1) << FRAC_BITS;
   localparam logic [NOISE_WIDTH-1:0] NOISE_RESET = NOISE_WIDTH'(655);

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASUREMENT_NOISE = 1'b1;

   // Item commands.
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

endpackage

`default_nettype wire

/* design/scalar_kalman_filter.sv */
// A filtered measurement passes through prepare, a bit-serial divide for the gain and a
// bit-serial multiply for the updates, then update and finish; the first measurement after
// a clear goes straight to finish, and a clear command gives no result. Finish waits until
// the output register is free; a new request is taken only once the sequencer is idle.
// Reset is synchronous: estimate 0, covariance 1.0, not primed, both noise registers 655.
`default_nettype none

module scalar_kalman_filter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_cmd,
   input  wire logic signed [skf_pkg::DATA_WIDTH-1:0] req_measurement,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [skf_pkg::DATA_WIDTH-1:0]      rsp_estimate,
   input  wire logic                                  csr_write_enable,
   input  wire logic [skf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [skf_pkg::NOISE_WIDTH-1:0]       csr_write_data
);
   import skf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic                           primed_ff, primed_in;
   logic signed [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]          p_ff, p_in;
   logic [NOISE_WIDTH-1:0]         q_ff, q_in;
   logic [NOISE_WIDTH-1:0]         r_ff, r_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0]   rsp_estimate_ff, rsp_estimate_in;

   logic [DATA_WIDTH-1:0]          pp_ff, pp_in;
   logic signed [DIFF_WIDTH-1:0]   diff_ff, diff_in;
   logic [DEN_WIDTH-1:0]           den_ff, den_in;
   logic [REM_WIDTH-1:0]           rem_ff, rem_in;
   logic [K_WIDTH-1:0]             k_ff, k_in;
   logic [CNT_WIDTH-1:0]           cnt_ff, cnt_in;
   logic signed [PX_WIDTH-1:0]     acc_x_ff, acc_x_in;
   logic [PP_WIDTH-1:0]            acc_p_ff, acc_p_in;

   logic                           req_fire;
   logic                           rsp_free;
   logic [DATA_WIDTH:0]            pred_sum;
   logic [REM_WIDTH:0]             trial;
   logic                           qbit;
   logic [REM_WIDTH-1:0]           rem_kept;
   logic [PP_WIDTH-1:0]            p_scaled;
   logic [PP_WIDTH-1:0]            p_left;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_estimate_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // Predicted covariance P + Q, saturated at the top of the word.
   assign pred_sum = {1'b0, p_ff} + {(DATA_WIDTH + 1 - NOISE_WIDTH)'(0), q_ff};

   // One restoring division step: the gain bit is set when the remainder covers the divisor.
   assign trial    = {1'b0, rem_ff} - {2'b00, den_ff};
   assign qbit     = !trial[REM_WIDTH] && (den_ff != '0);
   assign rem_kept = qbit ? trial[REM_WIDTH-1:0] : rem_ff;

   // (1 - K) * P is formed as P * 1.0 less P * K.
   assign p_scaled = {1'b0, pp_ff, FRAC_BITS'(0)};
   assign p_left   = p_scaled - acc_p_ff;

   // Next-state logic of the sequencer and its datapath.
   always_comb begin
      state_in        = state_ff;
      primed_in       = primed_ff;
      x_in            = x_ff;
      p_in            = p_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_estimate_in = rsp_estimate_ff;
      pp_in           = pp_ff;
      diff_in         = diff_ff;
      den_in          = den_ff;
      rem_in          = rem_ff;
      k_in            = k_ff;
      cnt_in          = cnt_ff;
      acc_x_in        = acc_x_ff;
      acc_p_in        = acc_p_ff;

      // The output register empties when its item is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     q_in = csr_write_data;
            CSR_MEASUREMENT_NOISE: r_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_CLEAR) begin
                  x_in      = '0;
                  p_in      = COV_ONE;
                  primed_in = 1'b0;
               end else if (!primed_ff) begin
                  x_in      = req_measurement;
                  primed_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  pp_in    = pred_sum[DATA_WIDTH] ? '1 : pred_sum[DATA_WIDTH-1:0];
                  diff_in  = {req_measurement[DATA_WIDTH-1], req_measurement}
                             - {x_ff[DATA_WIDTH-1], x_ff};
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            den_in   = {1'b0, pp_ff} + {(DEN_WIDTH - NOISE_WIDTH)'(0), r_ff};
            rem_in   = {2'b00, pp_ff};
            k_in     = '0;
            cnt_in   = CNT_WIDTH'(K_WIDTH - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            k_in   = {k_ff[K_WIDTH-2:0], qbit};
            rem_in = {rem_kept[REM_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               acc_x_in = '0;
               acc_p_in = '0;
               cnt_in   = CNT_WIDTH'(K_WIDTH - 1);
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            // Gain bits enter most significant first; both products share them.
            acc_x_in = (acc_x_ff <<< 1)
                       + (k_ff[K_WIDTH-1] ? PX_WIDTH'(diff_ff) : PX_WIDTH'(0));
            acc_p_in = (acc_p_ff << 1)
                       + (k_ff[K_WIDTH-1] ? {(K_WIDTH)'(0), pp_ff} : PP_WIDTH'(0));
            k_in     = {k_ff[K_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The arithmetic shift of the product floors the correction.
            x_in     = x_ff + acc_x_ff[FRAC_BITS +: DATA_WIDTH];
            p_in     = p_left[FRAC_BITS +: DATA_WIDTH];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_estimate_in = x_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, filter registers, datapath registers and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         x_ff         <= '0;
         p_ff         <= COV_ONE;
         q_ff         <= NOISE_RESET;
         r_ff         <= NOISE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_estimate_ff <= rsp_estimate_in;
      pp_ff           <= pp_in;
      diff_ff         <= diff_in;
      den_ff          <= den_in;
      rem_ff          <= rem_in;
      k_ff            <= k_in;
      cnt_ff          <= cnt_in;
      acc_x_ff        <= acc_x_in;
      acc_p_ff        <= acc_p_in;
   end

endmodule

`default_nettype wire
